FILE: sv/teq_pkg.sv
// Package for the timed event queue: word layouts, request and status codes,
// and sequencer states. Used by timed_event_queue_core.
package teq_pkg;

  localparam int unsigned TIME_W   = 31;
  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned HELD_W   = 5;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_POP    = 2'd1,
    KIND_REMOVE = 2'd2
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_FULL    = 3'd2,
    ST_DUP     = 3'd3,
    ST_MISSING = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DUP_RD,
    S_DUP_CHK,
    S_INS_RD,
    S_INS_CHK,
    S_FIND_RD,
    S_FIND_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_RESP
  } state_e;

  // register indexes on the APB port
  localparam int unsigned REG_DROP_DUP = 0;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [TIME_W-1:0]   event_time;
    logic [HANDLE_W-1:0] event_handle;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TIME_W-1:0]   out_time;
    logic [HANDLE_W-1:0] out_handle;
    logic [HELD_W-1:0]   entries_held;
  } out_word_t;

endpackage

FILE: sv/timed_event_queue_core.sv
// Timed event queue top level: sorted slot memory walked by a small sequencer.
// Depends on teq_pkg for word layouts, codes and states.

// The queue holds up to QUEUE_DEPTH events in one single-port-read memory,
// sorted by time with slot 0 earliest; equal times keep insertion order.
// One request is taken at a time: in_stall_o is high from acceptance until
// the result word is loaded into the output register, and the next request
// can be taken in the cycle after that. Every step reads one slot (registered
// read) and compares it in one shared compare unit, so cost grows with the
// slots walked. An insert walks from the tail toward its slot, moving each
// later event up one slot, after a scan of every held slot for an equal time
// when duplicate-time dropping is on; a dropped duplicate answers at the
// match. A pop and a remove walk every held slot, whether or not the handle
// is found. An insert into a full queue and an unused request go straight to
// the response, and a pop of an empty queue reads no slot. No clearing pass
// follows reset.
module timed_event_queue_core #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned HANDLE_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  teq_pkg::in_word_t   in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output teq_pkg::out_word_t  out_word_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [teq_pkg::TIME_W-1:0] t;
    logic [HANDLE_BITS-1:0]     h;
  } entry_t;

  // slot memory
  entry_t mem [QUEUE_DEPTH];
  entry_t rd_q;
  logic   mem_we, mem_re;
  logic [AW-1:0] mem_wa, mem_ra;
  entry_t mem_wd;

  teq_pkg::state_e state_q, state_d;
  logic [CW-1:0] occ_q, occ_d, idx_q, idx_d, idx_m1, idx_p1;
  logic [teq_pkg::KIND_W-1:0] kind_q;
  logic [teq_pkg::TIME_W-1:0] t_q;
  logic [HANDLE_BITS-1:0] h_q;
  teq_pkg::status_e status_q, status_d;
  logic [teq_pkg::TIME_W-1:0] ot_q, ot_d;
  logic [HANDLE_BITS-1:0] oh_q, oh_d;
  logic drop_q;
  logic out_valid_q;
  teq_pkg::out_word_t out_q;

  logic in_acc, resp_free, cfg_wr;
  logic [31:0] h_in_ext, oh_ext;
  logic full, is_pop;
  logic time_gt, time_eq, handle_eq;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign resp_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != teq_pkg::S_IDLE);
  assign idx_m1 = idx_q - CW'(1);
  assign idx_p1 = idx_q + CW'(1);
  assign full   = (occ_q == CW'(QUEUE_DEPTH));
  assign is_pop = (kind_q == teq_pkg::KIND_POP);
  assign h_in_ext = 32'(in_word_i.event_handle);
  assign oh_ext   = 32'(oh_q);

  // shared compare unit on the slot just read
  assign time_gt   = (rd_q.t > t_q);
  assign time_eq   = (rd_q.t == t_q);
  assign handle_eq = (rd_q.h == h_q);

  // APB register
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = {31'd0, drop_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drop_q <= 1'b0;
    end else if (cfg_wr && (32'(paddr[2]) == teq_pkg::REG_DROP_DUP)) begin
      drop_q <= pwdata[0];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      teq_pkg::S_IDLE: begin
        if (in_acc) begin
          priority if (in_word_i.kind == teq_pkg::KIND_INSERT) begin
            if (full) state_d = teq_pkg::S_RESP;
            else if (drop_q) state_d = teq_pkg::S_DUP_RD;
            else state_d = teq_pkg::S_INS_RD;
          end else if (in_word_i.kind == teq_pkg::KIND_POP ||
                       in_word_i.kind == teq_pkg::KIND_REMOVE) begin
            state_d = teq_pkg::S_FIND_RD;
          end else begin
            state_d = teq_pkg::S_RESP;
          end
        end
      end
      teq_pkg::S_DUP_RD:
        state_d = (idx_q == occ_q) ? teq_pkg::S_INS_RD : teq_pkg::S_DUP_CHK;
      teq_pkg::S_DUP_CHK:
        state_d = time_eq ? teq_pkg::S_RESP : teq_pkg::S_DUP_RD;
      teq_pkg::S_INS_RD:
        state_d = (idx_q == '0) ? teq_pkg::S_RESP : teq_pkg::S_INS_CHK;
      teq_pkg::S_INS_CHK:
        state_d = time_gt ? teq_pkg::S_INS_RD : teq_pkg::S_RESP;
      teq_pkg::S_FIND_RD:
        state_d = (idx_q == occ_q) ? teq_pkg::S_RESP : teq_pkg::S_FIND_CHK;
      teq_pkg::S_FIND_CHK:
        state_d = (is_pop || handle_eq) ? teq_pkg::S_SHIFT_RD : teq_pkg::S_FIND_RD;
      teq_pkg::S_SHIFT_RD:
        state_d = (idx_p1 == occ_q) ? teq_pkg::S_RESP : teq_pkg::S_SHIFT_WR;
      teq_pkg::S_SHIFT_WR:
        state_d = teq_pkg::S_SHIFT_RD;
      teq_pkg::S_RESP:
        if (resp_free) state_d = teq_pkg::S_IDLE;
      default: state_d = teq_pkg::S_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    idx_d    = idx_q;
    occ_d    = occ_q;
    status_d = status_q;
    ot_d     = ot_q;
    oh_d     = oh_q;
    mem_we   = 1'b0;
    mem_wa   = idx_q[AW-1:0];
    mem_wd   = '{t: t_q, h: h_q};
    mem_re   = 1'b0;
    mem_ra   = idx_q[AW-1:0];
    unique case (state_q)
      teq_pkg::S_IDLE: begin
        if (in_acc) begin
          ot_d     = '0;
          oh_d     = '0;
          status_d = teq_pkg::ST_OK;
          priority if (in_word_i.kind == teq_pkg::KIND_INSERT) begin
            if (full) status_d = teq_pkg::ST_FULL;
            idx_d = drop_q ? '0 : occ_q;
          end else if (in_word_i.kind == teq_pkg::KIND_POP) begin
            status_d = teq_pkg::ST_EMPTY;
            idx_d    = '0;
          end else if (in_word_i.kind == teq_pkg::KIND_REMOVE) begin
            status_d = teq_pkg::ST_MISSING;
            idx_d    = '0;
          end else begin
            idx_d = '0;
          end
        end
      end
      teq_pkg::S_DUP_RD: begin
        if (idx_q == occ_q) begin
          idx_d = occ_q;
        end else begin
          mem_re = 1'b1;
        end
      end
      teq_pkg::S_DUP_CHK: begin
        if (time_eq) status_d = teq_pkg::ST_DUP;
        else idx_d = idx_p1;
      end
      teq_pkg::S_INS_RD: begin
        if (idx_q == '0) begin
          // new event becomes the head
          mem_we = 1'b1;
          occ_d  = occ_q + CW'(1);
        end else begin
          mem_re = 1'b1;
          mem_ra = idx_m1[AW-1:0];
        end
      end
      teq_pkg::S_INS_CHK: begin
        mem_we = 1'b1;
        if (time_gt) begin
          // move the later event up one slot
          mem_wd = rd_q;
          idx_d  = idx_m1;
        end else begin
          occ_d = occ_q + CW'(1);
        end
      end
      teq_pkg::S_FIND_RD: begin
        if (idx_q != occ_q) mem_re = 1'b1;
      end
      teq_pkg::S_FIND_CHK: begin
        if (is_pop || handle_eq) begin
          status_d = teq_pkg::ST_OK;
          if (is_pop) begin
            ot_d = rd_q.t;
            oh_d = rd_q.h;
          end
        end else begin
          idx_d = idx_p1;
        end
      end
      teq_pkg::S_SHIFT_RD: begin
        if (idx_p1 == occ_q) begin
          occ_d = occ_q - CW'(1);
        end else begin
          mem_re = 1'b1;
          mem_ra = idx_p1[AW-1:0];
        end
      end
      teq_pkg::S_SHIFT_WR: begin
        // close the gap left by the removed event
        mem_we = 1'b1;
        mem_wd = rd_q;
        idx_d  = idx_p1;
      end
      teq_pkg::S_RESP: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rd_q <= mem[mem_ra];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q <= in_word_i.kind;
      t_q    <= in_word_i.event_time;
      h_q    <= h_in_ext[HANDLE_BITS-1:0];
    end
    idx_q    <= idx_d;
    status_q <= status_d;
    ot_q     <= ot_d;
    oh_q     <= oh_d;
    if (state_q == teq_pkg::S_RESP && resp_free) begin
      out_q.status       <= status_q;
      out_q.out_time     <= ot_q;
      out_q.out_handle   <= oh_ext[teq_pkg::HANDLE_W-1:0];
      out_q.entries_held <= teq_pkg::HELD_W'(occ_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= teq_pkg::S_IDLE;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      if (state_q == teq_pkg::S_RESP && resp_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // checks
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CW'(QUEUE_DEPTH))
    else $error("occupancy beyond queue depth");

  a_occ_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ_q != $past(occ_q)) |->
      (occ_q == $past(occ_q) + CW'(1) || occ_q == $past(occ_q) - CW'(1)))
    else $error("occupancy moved by more than one");

  a_wr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (CW'(mem_wa) <= occ_q))
    else $error("slot write outside the held range");

  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.status != teq_pkg::ST_OK) |->
      (out_word_o.out_time == '0 && out_word_o.out_handle == '0))
    else $error("failed request carries event fields");

endmodule

FILE: verif/tb_timed_event_queue_core.sv
// Testbench for timed_event_queue_core: random and directed requests over the
// valid/stall channels, results checked against a sorted-queue predictor.
// Depends on teq_pkg and the core; uses its APB port for the duplicate mode.
module tb_timed_event_queue_core;

  localparam int unsigned QUEUE_DEPTH   = 16;
  localparam int unsigned PHASES        = 10;
  localparam int unsigned PHASE_ITEMS   = 150;
  localparam int unsigned CALM_PHASE    = 2;
  localparam int unsigned HOLD_PHASE    = 4;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned CYCLE_LIMIT   = 1000000;

  localparam logic [teq_pkg::KIND_W-1:0]   KIND_UNUSED   = 2'd3;
  localparam logic [teq_pkg::TIME_W-1:0]   TIME_MAX      = {teq_pkg::TIME_W{1'b1}};
  localparam logic [teq_pkg::HANDLE_W-1:0] HANDLE_MAX    = {teq_pkg::HANDLE_W{1'b1}};
  localparam logic [2:0]                   DROP_DUP_ADDR = 3'(4 * teq_pkg::REG_DROP_DUP);

  typedef struct {
    logic [teq_pkg::TIME_W-1:0]   stamp;
    logic [teq_pkg::HANDLE_W-1:0] handle;
  } queued_event_t;

  class event_queue_scoreboard;
    queued_event_t      slots[$];
    teq_pkg::out_word_t expected_q[$];
    bit                 drop_dup;
    int                 failures;

    function void flag(string what, longint unsigned want, longint unsigned got);
      failures++;
      if (failures <= 10)
        $display("mismatch %0d: %s expected %0h got %0h", failures, what, want, got);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function int held();
      return slots.size();
    endfunction

    function logic [teq_pkg::HANDLE_W-1:0] some_handle();
      if (slots.size() == 0) return teq_pkg::HANDLE_W'($urandom());
      return slots[$urandom_range(slots.size() - 1)].handle;
    endfunction

    // Apply one accepted request to the queue copy and store its result word.
    function void note_request(teq_pkg::in_word_t w);
      teq_pkg::out_word_t r;
      queued_event_t      ev;
      int                 pos;
      bit                 hit;
      r = '0;
      r.status = teq_pkg::ST_OK;
      case (w.kind)
        teq_pkg::KIND_INSERT: begin
          hit = 1'b0;
          if (drop_dup)
            foreach (slots[i]) if (slots[i].stamp == w.event_time) hit = 1'b1;
          if (slots.size() >= QUEUE_DEPTH) begin
            r.status = teq_pkg::ST_FULL;
          end else if (hit) begin
            r.status = teq_pkg::ST_DUP;
          end else begin
            // go behind every queued event of equal or earlier time
            pos = 0;
            while (pos < slots.size() && slots[pos].stamp <= w.event_time) pos++;
            ev.stamp = w.event_time;
            ev.handle = w.event_handle;
            slots.insert(pos, ev);
          end
        end
        teq_pkg::KIND_POP: begin
          if (slots.size() == 0) begin
            r.status = teq_pkg::ST_EMPTY;
          end else begin
            ev = slots.pop_front();
            r.out_time = ev.stamp;
            r.out_handle = ev.handle;
          end
        end
        teq_pkg::KIND_REMOVE: begin
          r.status = teq_pkg::ST_MISSING;
          for (int i = 0; i < slots.size(); i++) begin
            if (slots[i].handle == w.event_handle) begin
              slots.delete(i);
              r.status = teq_pkg::ST_OK;
              break;
            end
          end
        end
        default: ;
      endcase
      r.entries_held = teq_pkg::HELD_W'(slots.size());
      expected_q.push_back(r);
    endfunction

    function void check_result(teq_pkg::out_word_t got);
      teq_pkg::out_word_t want;
      if (expected_q.size() == 0) begin
        flag("result word with none pending, status", 0, got.status);
      end else begin
        want = expected_q.pop_front();
        if (got.status !== want.status) flag("status", want.status, got.status);
        if (got.out_time !== want.out_time) flag("out_time", want.out_time, got.out_time);
        if (got.out_handle !== want.out_handle)
          flag("out_handle", want.out_handle, got.out_handle);
        if (got.entries_held !== want.entries_held)
          flag("entries_held", want.entries_held, got.entries_held);
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  teq_pkg::in_word_t  in_word_i;
  logic               out_valid_o;
  logic               out_stall_i;
  teq_pkg::out_word_t out_word_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  event_queue_scoreboard sb;
  bit calm;
  int hold_request;
  int cycle_count;

  timed_event_queue_core #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .HANDLE_BITS(teq_pkg::HANDLE_W)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic bit take_gap();
    return !calm && ($urandom_range(99) < 16);
  endfunction

  // Result side: random stalls, plus one long hold-off when asked for.
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= take_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_word_o);
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(input teq_pkg::in_word_t w);
    while (take_gap()) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(w);
    @(negedge clk_i);
  endtask

  task automatic send_op(input logic [teq_pkg::KIND_W-1:0] kind,
                         input logic [teq_pkg::TIME_W-1:0] stamp,
                         input logic [teq_pkg::HANDLE_W-1:0] handle);
    teq_pkg::in_word_t w;
    w.kind = kind;
    w.event_time = stamp;
    w.event_handle = handle;
    send_word(w);
  endtask

  // Drop valid and wait until every result word is back and the core is idle.
  task automatic drain_block();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic apb_access(input bit wr, input logic [2:0] addr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_drop_duplicate_time(input bit value);
    logic [31:0] readback;
    apb_access(1'b1, DROP_DUP_ADDR, {31'd0, value}, readback);
    sb.drop_dup = value;
    apb_access(1'b0, DROP_DUP_ADDR, '0, readback);
    if (readback !== {31'd0, value}) sb.flag("drop_duplicate_time readback", value, readback);
  endtask

  // Mostly inserts while filling, mostly pops and removes while draining.
  function automatic teq_pkg::in_word_t random_request(bit filling);
    teq_pkg::in_word_t w;
    int roll;
    roll = $urandom_range(99);
    w.event_time = teq_pkg::TIME_W'($urandom());
    w.event_handle = teq_pkg::HANDLE_W'($urandom());
    case ($urandom_range(3))
      0: w.event_time = teq_pkg::TIME_W'($urandom_range(12));
      1: w.event_time = TIME_MAX - teq_pkg::TIME_W'($urandom_range(3));
      default: ;
    endcase
    if ($urandom_range(4) == 0) w.event_handle = teq_pkg::HANDLE_W'($urandom_range(7));
    if (roll < 3) begin
      w.kind = KIND_UNUSED;
    end else if (roll < (filling ? 68 : 35)) begin
      w.kind = teq_pkg::KIND_INSERT;
    end else if (roll < (filling ? 83 : 68)) begin
      w.kind = teq_pkg::KIND_POP;
    end else begin
      w.kind = teq_pkg::KIND_REMOVE;
      if ($urandom_range(2) != 0) w.event_handle = sb.some_handle();
    end
    return w;
  endfunction

  initial begin : stimulus
    bit filling;
    sb = new();
    calm = 1'b0;
    hold_request = 0;
    cycle_count = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_word_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty queue, unused kind, extremes, ties, head removal, equal handles
    send_op(teq_pkg::KIND_POP, TIME_MAX, '0);
    send_op(teq_pkg::KIND_REMOVE, '0, HANDLE_MAX);
    send_op(KIND_UNUSED, TIME_MAX, HANDLE_MAX);
    send_op(teq_pkg::KIND_INSERT, TIME_MAX, HANDLE_MAX);
    send_op(teq_pkg::KIND_INSERT, '0, '0);
    send_op(teq_pkg::KIND_INSERT, 31'd100, 16'd7);
    send_op(teq_pkg::KIND_INSERT, 31'd100, 16'd7);
    send_op(teq_pkg::KIND_INSERT, 31'd100, 16'd5);
    send_op(teq_pkg::KIND_REMOVE, '0, '0);
    send_op(teq_pkg::KIND_REMOVE, '0, 16'd7);
    send_op(teq_pkg::KIND_REMOVE, '0, 16'h1234);
    send_op(teq_pkg::KIND_POP, '0, '0);
    send_op(teq_pkg::KIND_POP, '0, '0);
    repeat (QUEUE_DEPTH - 1)
      send_op(teq_pkg::KIND_INSERT, teq_pkg::TIME_W'($urandom()),
              teq_pkg::HANDLE_W'($urandom()));
    send_op(teq_pkg::KIND_INSERT, 31'd50, 16'd9);
    drain_block();
    // full check wins over the duplicate check
    set_drop_duplicate_time(1'b1);
    send_op(teq_pkg::KIND_INSERT, TIME_MAX, 16'd1);
    send_op(teq_pkg::KIND_POP, '0, '0);
    send_op(teq_pkg::KIND_INSERT, TIME_MAX, 16'd2);
    send_op(KIND_UNUSED, '0, '0);

    filling = 1'b1;
    for (int phase = 0; phase < PHASES; phase++) begin
      drain_block();
      set_drop_duplicate_time(phase == 0 ? 1'b0 : 1'($urandom_range(1)));
      calm = (phase == CALM_PHASE);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == HOLD_PHASE && n == 20) hold_request = HOLD_CYCLES;
        if (sb.held() >= QUEUE_DEPTH && $urandom_range(3) == 0) filling = 1'b0;
        else if (sb.held() == 0 && $urandom_range(2) == 0) filling = 1'b1;
        else if ($urandom_range(49) == 0) filling = !filling;
        send_word(random_request(filling));
      end
    end
    calm = 1'b0;
    drain_block();

    if (sb.failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
